// ===== sv/idll_pkg.sv =====
// shared types, constants and helper functions of the indexed doubly linked list
package idll_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 7;
    localparam int MAP_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES);
    localparam int LINK_D    = MAX_NODES + 2;

    localparam logic [NODE_W-1:0] HEAD_IX  = NODE_W'(0);
    localparam logic [NODE_W-1:0] FIRST_IX = NODE_W'(1);
    localparam logic [NODE_W-1:0] TAIL_IX  = NODE_W'(MAX_NODES + 1);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(MAX_NODES - 1);

    typedef enum logic [1:0] {
        KIND_INS_BEFORE = 2'd0,
        KIND_INS_AFTER  = 2'd1,
        KIND_REMOVE     = 2'd2,
        KIND_DUMP       = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_RM_IGN  = 3'd1,
        ST_INS_REJ = 3'd2,
        ST_ENTRY   = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    // operand sources for table addresses and write data
    typedef enum logic [2:0] {
        SRC_REF     = 3'd0,
        SRC_NEW     = 3'd1,
        SRC_RD_NEXT = 3'd2,
        SRC_RD_PREV = 3'd3,
        SRC_HEAD    = 3'd4
    } t_src;

    typedef struct packed {
        logic    take;
        logic    rd_en;
        t_src    rd_sel;
        logic    nx_we;
        t_src    nx_wa;
        t_src    nx_wd;
        logic    pv_we;
        t_src    pv_wa;
        t_src    pv_wd;
        logic    map_set;
        logic    map_clr;
        logic    cur_load;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    emit;
        logic    emit_cur;
        t_status emit_st;
        logic    emit_last;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  ins_ok;
        logic  rm_ok;
        logic  nxt_live;
        logic  cnt_last;
        logic  out_free;
    } t_sts;

    // node numbers 1..MAX_NODES are real list members
    function automatic logic node_live(input logic [NODE_W-1:0] v);
        return (v >= FIRST_IX) && (v <= NODE_W'(MAX_NODES));
    endfunction

    function automatic logic [NODE_W-1:0] next_rst(input logic [NODE_W-1:0] a);
        logic [NODE_W-1:0] r;
        r = '0;
        if (a == HEAD_IX) begin
            r = FIRST_IX;
        end else if (a == FIRST_IX) begin
            r = TAIL_IX;
        end
        return r;
    endfunction

    function automatic logic [NODE_W-1:0] prev_rst(input logic [NODE_W-1:0] a);
        logic [NODE_W-1:0] r;
        r = '0;
        if (a == FIRST_IX) begin
            r = HEAD_IX;
        end else if (a == TAIL_IX) begin
            r = FIRST_IX;
        end
        return r;
    endfunction

endpackage

// ===== sv/idll_in_if.sv =====
// command channel of the list block
interface idll_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [idll_pkg::NODE_W-1:0] ref_node;
    logic [idll_pkg::NODE_W-1:0] new_node;

    modport source (output valid, output kind, output ref_node, output new_node, input ready);
    modport sink   (input valid, input kind, input ref_node, input new_node, output ready);
endinterface

// ===== sv/idll_out_if.sv =====
// result channel of the list block
interface idll_out_if;
    logic                        valid;
    logic                        ready;
    logic [idll_pkg::NODE_W-1:0] node_id;
    logic [2:0]                  status;
    logic                        last;

    modport source (output valid, output node_id, output status, output last, input ready);
    modport sink   (input valid, input node_id, input status, input last, output ready);
endinterface

// ===== sv/idll_dp.sv =====
// datapath: link tables, presence map, walk pointer and result register
module idll_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  idll_pkg::t_cmd              i_cmd,
    output idll_pkg::t_sts              o_sts,
    input  logic [1:0]                  i_kind,
    input  logic [idll_pkg::NODE_W-1:0] i_ref_node,
    input  logic [idll_pkg::NODE_W-1:0] i_new_node,
    idll_out_if.source                  o_out
);
    localparam int NW = idll_pkg::NODE_W;

    logic [NW-1:0] r_nx_mem [0:idll_pkg::LINK_D-1];
    logic [NW-1:0] r_pv_mem [0:idll_pkg::LINK_D-1];
    logic [idll_pkg::LINK_D-1:0] r_nx_vld, r_pv_vld;
    logic [idll_pkg::MAX_NODES-1:0] r_map;

    idll_pkg::t_kind r_kind;
    logic [NW-1:0] r_ref, r_new, r_rd_addr, r_nx_q, r_pv_q, r_cur;
    logic          r_nx_vq, r_pv_vq;
    logic [idll_pkg::CNT_W-1:0] r_cnt;

    logic          r_out_vld, r_out_last;
    logic [NW-1:0] r_out_id;
    logic [2:0]    r_out_st;

    logic [NW-1:0] rd_next, rd_prev, rd_addr, nx_wa, nx_wd, pv_wa, pv_wd;
    logic [NW-1:0] ref_m1, new_m1;
    logic          ref_pres, new_pres;

    function automatic logic [NW-1:0] pick(input idll_pkg::t_src s,
                                           input logic [NW-1:0] rf,
                                           input logic [NW-1:0] nw,
                                           input logic [NW-1:0] rn,
                                           input logic [NW-1:0] rp);
        logic [NW-1:0] v;
        case (s)
            idll_pkg::SRC_REF:     v = rf;
            idll_pkg::SRC_NEW:     v = nw;
            idll_pkg::SRC_RD_NEXT: v = rn;
            idll_pkg::SRC_RD_PREV: v = rp;
            idll_pkg::SRC_HEAD:    v = idll_pkg::HEAD_IX;
            default:               v = idll_pkg::HEAD_IX;
        endcase
        return v;
    endfunction

    // entries never written read as their reset links
    assign rd_next = r_nx_vq ? r_nx_q : idll_pkg::next_rst(r_rd_addr);
    assign rd_prev = r_pv_vq ? r_pv_q : idll_pkg::prev_rst(r_rd_addr);

    assign rd_addr = pick(i_cmd.rd_sel, r_ref, r_new, rd_next, rd_prev);
    assign nx_wa   = pick(i_cmd.nx_wa,  r_ref, r_new, rd_next, rd_prev);
    assign nx_wd   = pick(i_cmd.nx_wd,  r_ref, r_new, rd_next, rd_prev);
    assign pv_wa   = pick(i_cmd.pv_wa,  r_ref, r_new, rd_next, rd_prev);
    assign pv_wd   = pick(i_cmd.pv_wd,  r_ref, r_new, rd_next, rd_prev);

    assign ref_m1   = r_ref - NW'(1);
    assign new_m1   = r_new - NW'(1);
    assign ref_pres = idll_pkg::node_live(r_ref) && r_map[ref_m1[idll_pkg::MAP_W-1:0]];
    assign new_pres = r_map[new_m1[idll_pkg::MAP_W-1:0]];

    always_comb begin
        o_sts.kind     = r_kind;
        o_sts.ins_ok   = ref_pres && idll_pkg::node_live(r_new) && !new_pres;
        o_sts.rm_ok    = ref_pres;
        o_sts.nxt_live = idll_pkg::node_live(rd_next);
        o_sts.cnt_last = (r_cnt == idll_pkg::CNT_LAST);
        o_sts.out_free = !r_out_vld || o_out.ready;
    end

    // link tables
    always_ff @(posedge i_clk) begin
        if (i_cmd.nx_we) begin
            r_nx_mem[nx_wa] <= nx_wd;
        end
        if (i_cmd.pv_we) begin
            r_pv_mem[pv_wa] <= pv_wd;
        end
        if (i_cmd.rd_en) begin
            r_nx_q    <= r_nx_mem[rd_addr];
            r_pv_q    <= r_pv_mem[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx_vld <= '0;
            r_pv_vld <= '0;
            r_nx_vq  <= 1'b0;
            r_pv_vq  <= 1'b0;
            r_map    <= idll_pkg::MAX_NODES'(1);
        end else begin
            if (i_cmd.rd_en) begin
                r_nx_vq <= r_nx_vld[rd_addr];
                r_pv_vq <= r_pv_vld[rd_addr];
            end
            if (i_cmd.nx_we) begin
                r_nx_vld[nx_wa] <= 1'b1;
            end
            if (i_cmd.pv_we) begin
                r_pv_vld[pv_wa] <= 1'b1;
            end
            if (i_cmd.map_set) begin
                r_map[new_m1[idll_pkg::MAP_W-1:0]] <= 1'b1;
            end
            if (i_cmd.map_clr) begin
                r_map[ref_m1[idll_pkg::MAP_W-1:0]] <= 1'b0;
            end
        end
    end

    // item fields, walk pointer and count
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_kind <= idll_pkg::t_kind'(i_kind);
            r_ref  <= i_ref_node;
            r_new  <= i_new_node;
        end
        if (i_cmd.cur_load) begin
            r_cur <= rd_next;
        end
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + idll_pkg::CNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_id   <= i_cmd.emit_cur ? r_cur : '0;
            r_out_st   <= i_cmd.emit_st;
            r_out_last <= i_cmd.emit_last;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.node_id = r_out_id;
    assign o_out.status  = r_out_st;
    assign o_out.last    = r_out_last;

endmodule

// ===== sv/idll_ctrl.sv =====
// controller: sequences table reads, writes and the dump walk
module idll_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  idll_pkg::t_sts i_sts,
    output idll_pkg::t_cmd o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_WR1   = 7'b0000100,
        S_WR2   = 7'b0001000,
        S_RESP  = 7'b0010000,
        S_DHEAD = 7'b0100000,
        S_DEMIT = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    idll_pkg::t_status r_st, n_st;
    logic ins_front, dump_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign ins_front  = (i_sts.kind == idll_pkg::KIND_INS_BEFORE);
    assign dump_last  = !i_sts.nxt_live || i_sts.cnt_last;

    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_sts.kind)
                    idll_pkg::KIND_DUMP: begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = idll_pkg::SRC_HEAD;
                        n_state      = S_DHEAD;
                    end
                    idll_pkg::KIND_REMOVE: begin
                        if (i_sts.rm_ok) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = idll_pkg::SRC_REF;
                            n_state      = S_WR1;
                        end else begin
                            n_st    = idll_pkg::ST_RM_IGN;
                            n_state = S_RESP;
                        end
                    end
                    default: begin
                        if (i_sts.ins_ok) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = idll_pkg::SRC_REF;
                            n_state      = S_WR1;
                        end else begin
                            n_st    = idll_pkg::ST_INS_REJ;
                            n_state = S_RESP;
                        end
                    end
                endcase
            end
            S_WR1: begin
                o_cmd.nx_we = 1'b1;
                o_cmd.pv_we = 1'b1;
                if (i_sts.kind == idll_pkg::KIND_REMOVE) begin
                    // bridge the neighbors of the removed node
                    o_cmd.nx_wa   = idll_pkg::SRC_RD_PREV;
                    o_cmd.nx_wd   = idll_pkg::SRC_RD_NEXT;
                    o_cmd.pv_wa   = idll_pkg::SRC_RD_NEXT;
                    o_cmd.pv_wd   = idll_pkg::SRC_RD_PREV;
                    o_cmd.map_clr = 1'b1;
                    n_st          = idll_pkg::ST_DONE;
                    n_state       = S_RESP;
                end else if (ins_front) begin
                    o_cmd.nx_wa = idll_pkg::SRC_RD_PREV;
                    o_cmd.nx_wd = idll_pkg::SRC_NEW;
                    o_cmd.pv_wa = idll_pkg::SRC_NEW;
                    o_cmd.pv_wd = idll_pkg::SRC_RD_PREV;
                    n_state     = S_WR2;
                end else begin
                    o_cmd.pv_wa = idll_pkg::SRC_RD_NEXT;
                    o_cmd.pv_wd = idll_pkg::SRC_NEW;
                    o_cmd.nx_wa = idll_pkg::SRC_NEW;
                    o_cmd.nx_wd = idll_pkg::SRC_RD_NEXT;
                    n_state     = S_WR2;
                end
            end
            S_WR2: begin
                o_cmd.nx_we   = 1'b1;
                o_cmd.pv_we   = 1'b1;
                o_cmd.map_set = 1'b1;
                if (ins_front) begin
                    o_cmd.nx_wa = idll_pkg::SRC_NEW;
                    o_cmd.nx_wd = idll_pkg::SRC_REF;
                    o_cmd.pv_wa = idll_pkg::SRC_REF;
                    o_cmd.pv_wd = idll_pkg::SRC_NEW;
                end else begin
                    o_cmd.pv_wa = idll_pkg::SRC_NEW;
                    o_cmd.pv_wd = idll_pkg::SRC_REF;
                    o_cmd.nx_wa = idll_pkg::SRC_REF;
                    o_cmd.nx_wd = idll_pkg::SRC_NEW;
                end
                n_st    = idll_pkg::ST_DONE;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_st   = r_st;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DHEAD: begin
                if (i_sts.nxt_live) begin
                    o_cmd.cur_load = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_sel   = idll_pkg::SRC_RD_NEXT;
                    n_state        = S_DEMIT;
                end else begin
                    n_st    = idll_pkg::ST_EMPTY;
                    n_state = S_RESP;
                end
            end
            S_DEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_cur  = 1'b1;
                    o_cmd.emit_st   = idll_pkg::ST_ENTRY;
                    o_cmd.emit_last = dump_last;
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.cur_load = 1'b1;
                        o_cmd.cnt_inc  = 1'b1;
                        o_cmd.rd_en    = 1'b1;
                        o_cmd.rd_sel   = idll_pkg::SRC_RD_NEXT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= idll_pkg::ST_DONE;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

endmodule

// ===== sv/indexed_doubly_linked_list.sv =====
// top level of the indexed doubly linked list of node numbers
//
// channel  dir  fields                          transfer when
// i_in     in   kind, ref_node, new_node        i_in.valid && i_in.ready
// o_out    out  node_id, status, last           o_out.valid && o_out.ready
//
// an insert loads its result after a check with table read, two write steps and the
// result step; a remove after check, one write step and result; a rejected insert or
// ignored removal after check and result; a dump reads the head, then loads one entry
// per member; an empty dump loads its single result after check and head read
// the link tables have one write port each, which sets the two write steps of an insert
// a dump walks the next table one read per node, stalled while the result is held
// reset leaves the list holding node 1 alone; no clearing pass, table entries
// never written read as their reset links through per-entry valid bits
// a new command transfers in the cycle after the previous one has placed its last
// result in the output register, even if that result is still waiting
module indexed_doubly_linked_list (
    input  logic       i_clk,
    input  logic       i_rst_n,
    idll_in_if.sink    i_in,
    idll_out_if.source o_out
);
    idll_pkg::t_cmd cmd;
    idll_pkg::t_sts sts;
    logic           in_ready;

    // controller only sees handshake and status, the datapath commands and item fields
    idll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    idll_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_kind     (i_in.kind),
        .i_ref_node (i_in.ref_node),
        .i_new_node (i_in.new_node),
        .o_out      (o_out)
    );

    // one command in flight at a time
    assign i_in.ready = in_ready;

endmodule
